### hdl/vn2d_pkg.sv
// Shared types, hash constants and lattice hash helpers for the 2D value noise block.
package vn2d_pkg;

  typedef struct packed {
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] noise_value;
    logic            saturated;
  } out_t;

  localparam logic [31:0] HASH_Y_MUL = 32'd57;
  localparam int          HASH_SHIFT = 13;
  localparam logic [31:0] HASH_C1    = 32'd15731;
  localparam logic [31:0] HASH_C2    = 32'd789221;
  localparam logic [31:0] HASH_C3    = 32'd1376312589;
  localparam logic [31:0] HASH_MASK  = 32'h7fffffff;
  localparam logic signed [31:0] LAT_ONE = 32'sh40000000;

  localparam logic [15:0] PERS_RESET = 16'd2048;
  localparam int          AMP_FRAC   = 12;

  localparam logic signed [63:0] S32_MAX = 64'sh000000007fffffff;
  localparam logic signed [63:0] S32_MIN = -64'sh0000000080000000;

  // Seed of the lattice hash: n = x + 57y, then fold in n << 13.
  function automatic logic [31:0] hash_seed(logic [31:0] x, logic [31:0] y);
    logic [31:0] n;
    n = x + y * HASH_Y_MUL;
    return n ^ (n << HASH_SHIFT);
  endfunction

  // Map the hash product to the signed lattice value 2^30 - h.
  function automatic logic signed [31:0] lat_value(logic [31:0] p);
    logic [31:0] h;
    h = (p + HASH_C3) & HASH_MASK;
    return LAT_ONE - $signed(h);
  endfunction

endpackage

### hdl/value_noise_2d_octaves.sv
// Four-octave fractal 2D hash value noise, fully pipelined; top level.
// Takes one point per cycle while the output is not stalled and returns one result
// per point. Every octave has its own sixteen lattice hash units (a 4x4 grid
// around the cell), so the rate is set by nothing but the stall on the output
// side; a stall freezes the whole pipeline. Octave amplitudes are derived from
// persistence by a small registered chain that follows each persistence write.
module value_noise_2d_octaves #(
  parameter int OCTAVES   = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  vn2d_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output vn2d_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_data_i
);

  localparam int NSTG   = 20;
  localparam int W_W    = FRAC_BITS + 1;
  localparam int P1_W   = 37 + W_W;
  localparam int P2_W   = 38 + W_W;
  localparam int NF_W   = FRAC_BITS + 6;
  localparam int AMP_W  = 4 * OCTAVES + 9;
  localparam int PC_W   = NF_W + AMP_W + 1;
  localparam int C_W    = PC_W - 11;
  localparam int SUM_W  = (C_W + 3 > 33) ? C_W + 3 : 33;
  localparam int NSH    = 34 - FRAC_BITS;
  localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(1 << vn2d_pkg::AMP_FRAC);

  function automatic logic [31:0] int_part(logic [31:0] u);
    logic [31:0] mag;
    logic [31:0] ip;
    mag = u[31] ? (32'd0 - u) : u;
    ip  = mag >> FRAC_BITS;
    return u[31] ? (32'd0 - ip) : ip;
  endfunction

  function automatic logic signed [W_W-1:0] frac_part(logic [31:0] u);
    logic [31:0]    mag;
    logic [W_W-1:0] f;
    mag = u[31] ? (32'd0 - u) : u;
    f   = {1'b0, mag[FRAC_BITS-1:0]};
    return $signed(u[31] ? (W_W'(0) - f) : f);
  endfunction

  function automatic logic [AMP_W-1:0] amp_next(logic [AMP_W-1:0] a, logic [15:0] p);
    logic [AMP_W+16:0] t;
    t = (AMP_W+17)'(a) * (AMP_W+17)'(p) + ((AMP_W+17)'(1) << (vn2d_pkg::AMP_FRAC - 1));
    return AMP_W'(t >> vn2d_pkg::AMP_FRAC);
  endfunction

  logic                 advance;
  logic [NSTG-1:0]      valid_q;
  logic [15:0]          pers_q;
  logic [AMP_W-1:0]     amp_q [OCTAVES];
  vn2d_pkg::in_t        in_q;
  logic signed [C_W-1:0]   contrib [OCTAVES];
  logic signed [SUM_W-1:0] sum_d, sum_q;
  vn2d_pkg::out_t       out_q;

  // Advance unless the finished result is held by the receiver.
  assign advance     = ~(valid_q[NSTG-1] & out_stall_i);
  assign in_stall_o  = ~advance;
  assign out_valid_o = valid_q[NSTG-1];
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      pers_q  <= vn2d_pkg::PERS_RESET;
    end else begin
      if (advance) begin
        valid_q <= {valid_q[NSTG-2:0], in_valid_i};
      end
      if (cfg_we_i) begin
        pers_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    amp_q[0] <= AMP_ONE;
    for (int k = 1; k < OCTAVES; k++) begin
      amp_q[k] <= amp_next(amp_q[k-1], pers_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      in_q <= in_data_i;
    end
  end

  for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
    logic [31:0]             cx, cy;
    logic [31:0]             ix_q, iy_q;
    logic signed [W_W-1:0]   fx_q, fy_q;
    logic signed [W_W-1:0]   fxd_q [8];
    logic signed [W_W-1:0]   fyd_q [11];
    logic [31:0]             n_q  [4][4];
    logic [31:0]             nb_q [4][4];
    logic [31:0]             sq_q [4][4];
    logic [31:0]             nc_q [4][4];
    logic [31:0]             t_q  [4][4];
    logic [31:0]             p_q  [4][4];
    logic signed [31:0]      lv_q [4][4];
    logic signed [35:0]      rs_q [4][2];
    logic signed [35:0]      cs_q [2][2];
    logic signed [35:0]      a_q  [2];
    logic signed [36:0]      d_q  [2];
    logic signed [35:0]      a2_q [2];
    logic signed [P1_W-1:0]  pr_q [2];
    logic signed [P1_W:0]    acc1 [2];
    logic signed [36:0]      i_q  [2];
    logic signed [36:0]      b_q, b2_q;
    logic signed [37:0]      e_q;
    logic signed [P2_W-1:0]  pr2_q;
    logic signed [P2_W:0]    acc2;
    logic signed [38:0]      nv_q;
    logic signed [39:0]      acc3;
    logic signed [NF_W-1:0]  nf_q;
    logic signed [PC_W-1:0]  pc_q;
    logic signed [PC_W:0]    acc4;
    logic signed [C_W-1:0]   ct_q;

    // Scale by 2^o with 32-bit wrap.
    assign cx = 32'(in_q.coord_x) << o;
    assign cy = 32'(in_q.coord_y) << o;
    assign contrib[o] = ct_q;

    always_comb begin
      for (int k = 0; k < 2; k++) begin
        acc1[k] = ((P1_W+1)'(a2_q[k]) <<< FRAC_BITS) + (P1_W+1)'(pr_q[k])
                + ((P1_W+1)'(1) <<< (FRAC_BITS - 1));
      end
      acc2 = ((P2_W+1)'(b2_q) <<< FRAC_BITS) + (P2_W+1)'(pr2_q)
           + ((P2_W+1)'(1) <<< (FRAC_BITS - 1));
      acc3 = 40'(nv_q) + (40'(1) <<< (NSH - 1));
      acc4 = (PC_W+1)'(pc_q) + ((PC_W+1)'(1) <<< (vn2d_pkg::AMP_FRAC - 1));
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        ix_q <= int_part(cx);
        iy_q <= int_part(cy);
        fx_q <= frac_part(cx);
        fy_q <= frac_part(cy);

        fxd_q[0] <= fx_q;
        for (int k = 1; k < 8; k++) fxd_q[k] <= fxd_q[k-1];
        fyd_q[0] <= fy_q;
        for (int k = 1; k < 11; k++) fyd_q[k] <= fyd_q[k-1];

        for (int j = 0; j < 4; j++) begin
          for (int i = 0; i < 4; i++) begin
            n_q[j][i]  <= vn2d_pkg::hash_seed(ix_q + 32'(i) - 32'd1,
                                              iy_q + 32'(j) - 32'd1);
            nb_q[j][i] <= n_q[j][i];
            sq_q[j][i] <= n_q[j][i] * n_q[j][i];
            nc_q[j][i] <= nb_q[j][i];
            t_q[j][i]  <= sq_q[j][i] * vn2d_pkg::HASH_C1 + vn2d_pkg::HASH_C2;
            p_q[j][i]  <= nc_q[j][i] * t_q[j][i];
            lv_q[j][i] <= vn2d_pkg::lat_value(p_q[j][i]);
          end
        end

        // Weight 1-2-1 along x, then along y.
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 2; c++) begin
            rs_q[r][c] <= 36'(lv_q[r][c]) + (36'(lv_q[r][c+1]) <<< 1) + 36'(lv_q[r][c+2]);
          end
        end
        for (int r = 0; r < 2; r++) begin
          for (int c = 0; c < 2; c++) begin
            cs_q[r][c] <= rs_q[r][c] + (rs_q[r+1][c] <<< 1) + rs_q[r+2][c];
          end
        end

        for (int k = 0; k < 2; k++) begin
          a_q[k]  <= cs_q[k][0];
          d_q[k]  <= 37'(cs_q[k][1]) - 37'(cs_q[k][0]);
          a2_q[k] <= a_q[k];
          pr_q[k] <= P1_W'(d_q[k]) * P1_W'(fxd_q[7]);
          i_q[k]  <= 37'(acc1[k] >>> FRAC_BITS);
        end

        b_q   <= i_q[0];
        e_q   <= 38'(i_q[1]) - 38'(i_q[0]);
        b2_q  <= b_q;
        pr2_q <= P2_W'(e_q) * P2_W'(fyd_q[10]);
        nv_q  <= 39'(acc2 >>> FRAC_BITS);
        nf_q  <= NF_W'(acc3 >>> NSH);
        pc_q  <= PC_W'(nf_q) * PC_W'($signed({1'b0, amp_q[o]}));
        ct_q  <= C_W'(acc4 >>> vn2d_pkg::AMP_FRAC);
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < OCTAVES; k++) begin
      sum_d = sum_d + SUM_W'(contrib[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sum_q <= sum_d;
      // Clip to the signed 32-bit range and flag it.
      if (sum_q > SUM_W'(vn2d_pkg::S32_MAX)) begin
        out_q.noise_value <= 32'(vn2d_pkg::S32_MAX);
        out_q.saturated   <= 1'b1;
      end else if (sum_q < SUM_W'(vn2d_pkg::S32_MIN)) begin
        out_q.noise_value <= 32'(vn2d_pkg::S32_MIN);
        out_q.saturated   <= 1'b1;
      end else begin
        out_q.noise_value <= 32'(sum_q);
        out_q.saturated   <= 1'b0;
      end
    end
  end

endmodule
